// ----- src/i2c_mbe_pkg.sv -----
// types, codes and reset values shared by the i2c master bit engine
// no dependencies
package i2c_mbe_pkg;

  localparam int unsigned CfgW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgW-1:0] HalfPeriodReset = 16'd100;
  localparam logic [CfgW-1:0] AckPollReset = 16'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HALF_PERIOD = 8'd0,
    REG_ACK_POLL    = 8'd1
  } reg_idx_e;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_NACK  = 3'd5
  } cmd_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_ST_A     = 4'd1,
    PH_ST_B     = 4'd2,
    PH_SP_A     = 4'd3,
    PH_SP_B     = 4'd4,
    PH_WR_LOW   = 4'd5,
    PH_WR_HIGH  = 4'd6,
    PH_ACK_LOW  = 4'd7,
    PH_ACK_POLL = 4'd8,
    PH_RD_LOW   = 4'd9,
    PH_RD_HIGH  = 4'd10,
    PH_MA_LOW   = 4'd11,
    PH_MA_HIGH  = 4'd12,
    PH_NK_LOW   = 4'd13,
    PH_NK_HIGH  = 4'd14
  } phase_e;

  typedef struct packed {
    logic [CfgW-1:0] half_period;
    logic [CfgW-1:0] ack_poll_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       mode;
    logic [ByteW-1:0] write_data;
    logic             sda_sample;
  } word_t;

  typedef struct packed {
    logic             scl_level;
    logic             sda_level;
    logic             busy;
    logic             done;
    logic             ack_ok;
    logic [ByteW-1:0] read_data;
  } result_t;

  typedef struct packed {
    phase_e           phase;
    logic [3:0]       bit_count;
    logic [ByteW-1:0] shift_byte;
    logic [CfgW-1:0]  wait_count;
    logic [CfgW-1:0]  poll_count;
    logic             scl_drive;
    logic             sda_drive;
    logic             ack_flag;
    logic [ByteW-1:0] read_latch;
  } seq_state_t;

endpackage

// ----- src/i2c_mbe_cfg.sv -----
// configuration registers: half period and ack poll limit
// depends on i2c_mbe_pkg
module i2c_mbe_cfg import i2c_mbe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_HALF_PERIOD: cfg_d.half_period = cfg_data_i;
        REG_ACK_POLL:    cfg_d.ack_poll_limit = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period <= HalfPeriodReset;
      cfg_q.ack_poll_limit <= AckPollReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/i2c_mbe_seq.sv -----
// line sequencer: phase state and the per-tick step logic
// depends on i2c_mbe_pkg
module i2c_mbe_seq import i2c_mbe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  word_t   word_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  seq_state_t st_q, st_d;

  always_comb begin
    logic [CfgW-1:0] half;
    logic [CfgW-1:0] limit;
    logic [CfgW:0]   wc_next;
    logic            scl_out;
    logic            sda_out;
    logic            done;
    logic [3:0]      bc_inc;

    half = (cfg_i.half_period == '0) ? CfgW'(1) : cfg_i.half_period;
    limit = (cfg_i.ack_poll_limit == '0) ? CfgW'(1) : cfg_i.ack_poll_limit;
    st_d = st_q;
    done = 1'b0;
    bc_inc = '0;

    if (st_q.phase == PH_IDLE && word_i.mode inside {[CMD_START:CMD_NACK]}) begin
      st_d.bit_count = '0;
      st_d.wait_count = '0;
      case (word_i.mode)
        CMD_START: begin
          st_d.phase = PH_ST_A;
          st_d.scl_drive = 1'b1;
          st_d.sda_drive = 1'b1;
        end
        CMD_STOP: begin
          st_d.phase = PH_SP_A;
          st_d.scl_drive = 1'b1;
          st_d.sda_drive = 1'b0;
        end
        CMD_WRITE: begin
          st_d.shift_byte = word_i.write_data;
          st_d.phase = PH_WR_LOW;
          st_d.scl_drive = 1'b0;
        end
        CMD_READ: begin
          st_d.shift_byte = '0;
          st_d.phase = PH_RD_LOW;
          st_d.scl_drive = 1'b0;
          st_d.sda_drive = 1'b1;
        end
        default: begin
          st_d.phase = PH_NK_LOW;
          st_d.scl_drive = 1'b0;
          st_d.sda_drive = 1'b1;
        end
      endcase
    end

    scl_out = st_d.scl_drive;
    sda_out = st_d.sda_drive;
    wc_next = {1'b0, st_d.wait_count} + 1'b1;

    if (st_d.phase == PH_ACK_POLL) begin
      if (!word_i.sda_sample) begin
        st_d.ack_flag = 1'b1;
        st_d.scl_drive = 1'b0;
        st_d.phase = PH_IDLE;
        done = 1'b1;
      end else begin
        if (st_d.poll_count != '1) begin
          st_d.poll_count = st_d.poll_count + 1'b1;
        end
        if (st_d.poll_count >= limit) begin
          st_d.ack_flag = 1'b0;
          st_d.scl_drive = 1'b0;
          st_d.phase = PH_IDLE;
          done = 1'b1;
        end
      end
    end else if (st_d.phase != PH_IDLE) begin
      if (st_d.phase == PH_RD_HIGH && st_d.wait_count == '0) begin
        st_d.shift_byte = {st_d.shift_byte[ByteW-2:0], word_i.sda_sample};
      end
      bc_inc = st_d.bit_count + 1'b1;
      if (wc_next < {1'b0, half}) begin
        st_d.wait_count = wc_next[CfgW-1:0];
      end else begin
        st_d.wait_count = '0;
        case (st_d.phase)
          PH_ST_A: begin
            st_d.phase = PH_ST_B;
            st_d.scl_drive = 1'b1;
            st_d.sda_drive = 1'b0;
          end
          PH_SP_A: begin
            st_d.phase = PH_SP_B;
            st_d.scl_drive = 1'b1;
            st_d.sda_drive = 1'b1;
          end
          PH_WR_LOW: begin
            st_d.phase = PH_WR_HIGH;
            st_d.scl_drive = 1'b1;
            st_d.sda_drive = st_d.shift_byte[ByteW-1];
            st_d.shift_byte = {st_d.shift_byte[ByteW-2:0], 1'b0};
          end
          PH_WR_HIGH: begin
            st_d.bit_count = bc_inc;
            st_d.scl_drive = 1'b0;
            if (bc_inc >= 4'd8) begin
              st_d.phase = PH_ACK_LOW;
              st_d.sda_drive = 1'b1;
            end else begin
              st_d.phase = PH_WR_LOW;
            end
          end
          PH_ACK_LOW: begin
            st_d.phase = PH_ACK_POLL;
            st_d.scl_drive = 1'b1;
            st_d.sda_drive = 1'b1;
            st_d.poll_count = '0;
          end
          PH_RD_LOW: begin
            st_d.phase = PH_RD_HIGH;
            st_d.scl_drive = 1'b1;
            st_d.sda_drive = 1'b1;
          end
          PH_RD_HIGH: begin
            st_d.bit_count = bc_inc;
            st_d.scl_drive = 1'b0;
            if (bc_inc >= 4'd8) begin
              st_d.read_latch = st_d.shift_byte;
              st_d.phase = PH_MA_LOW;
              st_d.sda_drive = 1'b0;
            end else begin
              st_d.phase = PH_RD_LOW;
              st_d.sda_drive = 1'b1;
            end
          end
          PH_MA_LOW: begin
            st_d.phase = PH_MA_HIGH;
            st_d.scl_drive = 1'b1;
            st_d.sda_drive = 1'b0;
          end
          PH_NK_LOW: begin
            st_d.phase = PH_NK_HIGH;
            st_d.scl_drive = 1'b1;
            st_d.sda_drive = 1'b1;
          end
          default: begin
            st_d.phase = PH_IDLE;
            done = 1'b1;
          end
        endcase
      end
    end

    result_o.scl_level = scl_out;
    result_o.sda_level = sda_out;
    result_o.busy = (st_d.phase != PH_IDLE);
    result_o.done = done;
    result_o.ack_ok = st_d.ack_flag;
    result_o.read_data = st_d.read_latch;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase <= PH_IDLE;
      st_q.bit_count <= '0;
      st_q.shift_byte <= '0;
      st_q.wait_count <= '0;
      st_q.poll_count <= '0;
      st_q.scl_drive <= 1'b1;
      st_q.sda_drive <= 1'b1;
      st_q.ack_flag <= 1'b0;
      st_q.read_latch <= '0;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule

// ----- src/i2c_master_bit_engine_top.sv -----
// i2c master bit engine top: input register, sequencer, result register
// depends on i2c_mbe_pkg, i2c_mbe_cfg, i2c_mbe_seq
//
// Each input word is one clock tick of the i2c bit engine and yields exactly one
// result word. The block takes one word per clock cycle while the result side
// does not stall; each word is held in the input register and its result in
// the result register, and a stall on the result side holds the input side
// only once both registers are full. The sequencer state advances by one tick
// as each word moves from the input register to the result register.
// Configuration registers (half period at index 0, ack poll limit at index 1)
// are written with cfg_valid_i and are always ready; other indexes are ignored.
module i2c_master_bit_engine_top import i2c_mbe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         mode_i,
  input  logic [ByteW-1:0]   write_data_i,
  input  logic               sda_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               scl_level_o,
  output logic               sda_level_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output logic               ack_ok_o,
  output logic [ByteW-1:0]   read_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  cfg_t    cfg;
  word_t   word_q;
  logic    word_valid_q;
  result_t res_d, res_q;
  logic    res_valid_q;
  logic    step;

  assign step = word_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !word_valid_q || step;

  i2c_mbe_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  i2c_mbe_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .word_i   (word_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      word_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q.mode <= mode_i;
      word_q.write_data <= write_data_i;
      word_q.sda_sample <= sda_sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign scl_level_o = res_q.scl_level;
  assign sda_level_o = res_q.sda_level;
  assign busy_res_o  = res_q.busy;
  assign done_res_o  = res_q.done;
  assign ack_ok_o    = res_q.ack_ok;
  assign read_data_o = res_q.read_data;

endmodule
